### rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the servo pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Widths fixed by the item and register formats
  localparam int unsigned CmdW      = 2;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned PortW     = 8;
  localparam int unsigned ReloadW   = 16;
  localparam int unsigned PosW      = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned FramesW   = 5;

  // Default servo count and number of position registers
  localparam int unsigned ServoCountDef = 8;
  localparam int unsigned NumPosRegs    = 8;

  // Frames a servo stays armed after it is picked
  localparam logic [FramesW-1:0] PulseFrames = FramesW'(25);

  // Timer reloads for an up-counting 16-bit timer (value = 65536 - interval)
  localparam logic [ReloadW-1:0] PulseBaseReload = ReloadW'(65536 - 3000);
  localparam logic [ReloadW-1:0] FrameReload     = ReloadW'(65536 - 40000);

  typedef enum logic [CmdW-1:0] {
    CmdEvent  = 2'd0,
    CmdTick   = 2'd1,
    CmdExpiry = 2'd2
  } sps_cmd_e;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [IdxW-1:0] servo_number;
    logic            turn_on;
  } sps_item_t;

  typedef struct packed {
    logic [PortW-1:0]   port_bits;
    logic [ReloadW-1:0] timer_reload;
  } sps_result_t;

  typedef struct packed {
    logic [PortW-1:0]   active_mask;
    logic [FramesW-1:0] frames_left;
  } sps_status_t;

endpackage

### rtl/core/sps_in_reg.sv
// ----------------------------------------------------------------------------
// sps_in_reg
// Input register: captures one transaction and holds it until the engine
// takes it.
// ----------------------------------------------------------------------------
module sps_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sps_pkg::sps_item_t item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output sps_pkg::sps_item_t item_o
);

  logic               valid_q, valid_d;
  sps_pkg::sps_item_t item_q;
  logic               load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/sps_engine.sv
// ----------------------------------------------------------------------------
// sps_engine
// Sequencer state, position registers and the per-transaction update.
// ----------------------------------------------------------------------------
module sps_engine #(
  parameter int unsigned SERVO_COUNT = sps_pkg::ServoCountDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sps_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              fire_i,
  input  sps_pkg::sps_item_t                item_i,
  output logic                              res_valid_o,
  output sps_pkg::sps_result_t              res_o,
  output sps_pkg::sps_status_t              status_o
);

  localparam int unsigned PosAddrW = $clog2(sps_pkg::NumPosRegs);

  logic [sps_pkg::CfgDataW-1:0] positions_q [sps_pkg::NumPosRegs];

  logic [SERVO_COUNT-1:0]         target_on_q, target_on_d;
  logic [SERVO_COUNT-1:0]         pending_q, pending_d;
  logic [SERVO_COUNT-1:0]         active_mask_q, active_mask_d;
  logic [sps_pkg::IdxW-1:0]       active_index_q, active_index_d;
  logic [sps_pkg::FramesW-1:0]    frames_left_q, frames_left_d;
  logic                           pulse_phase_q, pulse_phase_d;
  logic [sps_pkg::PortW-1:0]      staged_port_q, staged_port_d;
  logic [sps_pkg::ReloadW-1:0]    staged_reload_q, staged_reload_d;

  logic [SERVO_COUNT-1:0]         event_bit;
  logic                           event_in_range;
  logic [SERVO_COUNT-1:0]         pick_bit;
  logic [sps_pkg::IdxW-1:0]       pick_idx;
  logic [sps_pkg::CfgDataW-1:0]   pos_pair;
  logic [sps_pkg::PosW-1:0]       pos;
  logic [sps_pkg::PortW-1:0]      active_port;
  logic [sps_pkg::FramesW-1:0]    frames_dec;

  // Position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(sps_pkg::NumPosRegs); i++) begin
        positions_q[i] <= '0;
      end
    end else if (cfg_we_i &&
                 (cfg_index_i < sps_pkg::CfgIndexW'(sps_pkg::NumPosRegs))) begin
      positions_q[cfg_index_i[PosAddrW-1:0]] <= cfg_data_i;
    end
  end

  // Decode the addressed servo
  always_comb begin
    event_in_range = ({1'b0, item_i.servo_number} < (sps_pkg::IdxW + 1)'(SERVO_COUNT));
    for (int i = 0; i < int'(SERVO_COUNT); i++) begin
      event_bit[i] = (item_i.servo_number == sps_pkg::IdxW'(i));
    end
  end

  // Lowest pending request wins
  always_comb begin
    pick_bit = '0;
    pick_idx = '0;
    for (int i = int'(SERVO_COUNT) - 1; i >= 0; i--) begin
      if (pending_q[i]) begin
        pick_bit    = '0;
        pick_bit[i] = 1'b1;
        pick_idx    = sps_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    active_port = '0;
    active_port[SERVO_COUNT-1:0] = active_mask_q;
  end

  assign pos_pair   = positions_q[active_index_q[PosAddrW-1:0]];
  assign pos        = ((target_on_q & active_mask_q) != '0) ?
                      pos_pair[sps_pkg::CfgDataW-1:sps_pkg::PosW] :
                      pos_pair[sps_pkg::PosW-1:0];
  assign frames_dec = frames_left_q - sps_pkg::FramesW'(1);

  always_comb begin
    target_on_d     = target_on_q;
    pending_d       = pending_q;
    active_mask_d   = active_mask_q;
    active_index_d  = active_index_q;
    frames_left_d   = frames_left_q;
    pulse_phase_d   = pulse_phase_q;
    staged_port_d   = staged_port_q;
    staged_reload_d = staged_reload_q;
    res_valid_o     = 1'b0;
    if (fire_i) begin
      case (sps_pkg::sps_cmd_e'(item_i.cmd))
        sps_pkg::CmdEvent: begin
          if (event_in_range) begin
            pending_d = pending_q | event_bit;
            if (item_i.turn_on) begin
              target_on_d = target_on_q | event_bit;
            end else begin
              target_on_d = target_on_q & ~event_bit;
            end
          end
        end
        sps_pkg::CmdTick: begin
          if ((frames_left_q == '0) && (pending_q != '0)) begin
            pending_d      = pending_q & ~pick_bit;
            active_mask_d  = pick_bit;
            active_index_d = pick_idx;
            frames_left_d  = sps_pkg::PulseFrames;
          end
        end
        sps_pkg::CmdExpiry: begin
          res_valid_o   = 1'b1;
          staged_port_d = '0;
          if (active_mask_q != '0) begin
            if (!pulse_phase_q) begin
              // Start of pulse: drive the line for 3000 + 8 * position
              staged_port_d   = active_port;
              staged_reload_d = sps_pkg::PulseBaseReload -
                                {5'b0, pos, 3'b0};
              pulse_phase_d   = 1'b1;
            end else begin
              // Rest of the frame after the pulse
              staged_reload_d = sps_pkg::FrameReload - staged_reload_q;
              pulse_phase_d   = 1'b0;
              frames_left_d   = frames_dec;
              if (frames_dec == '0) begin
                active_mask_d = '0;
              end
            end
          end else begin
            staged_reload_d = sps_pkg::FrameReload;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_on_q     <= '0;
      pending_q       <= '0;
      active_mask_q   <= '0;
      active_index_q  <= '0;
      frames_left_q   <= '0;
      pulse_phase_q   <= 1'b1;
      staged_port_q   <= '0;
      staged_reload_q <= '0;
    end else begin
      target_on_q     <= target_on_d;
      pending_q       <= pending_d;
      active_mask_q   <= active_mask_d;
      active_index_q  <= active_index_d;
      frames_left_q   <= frames_left_d;
      pulse_phase_q   <= pulse_phase_d;
      staged_port_q   <= staged_port_d;
      staged_reload_q <= staged_reload_d;
    end
  end

  // Result carries the pair staged by the previous expiry
  assign res_o.port_bits    = staged_port_q;
  assign res_o.timer_reload = staged_reload_q;

  assign status_o.active_mask = active_port;
  assign status_o.frames_left = frames_left_q;

endmodule

### rtl/core/sps_out_reg.sv
// ----------------------------------------------------------------------------
// sps_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module sps_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  sps_pkg::sps_result_t res_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sps_pkg::sps_result_t res_o
);

  logic                 valid_q;
  sps_pkg::sps_result_t res_q;

  // Advance whenever the register is empty or is being drained
  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/servo_pulse_sequencer.sv
// The result of a timer expiry transaction passes the input register, then the result register, before it is presented.
// Throughput: one transaction per cycle; input register, state update and
// result register each pass one transaction per clock while the sink is ready.
// Ready drops only while the result register holds a result the sink has not taken.
// Reset (rst_ni low, asynchronous): positions, targets, requests and timing clear,
// pulse phase set, both pipeline registers empty.
// ----------------------------------------------------------------------------
// servo_pulse_sequencer
// RC servo pulse sequencer: pulses one of up to eight servos at a time and
// hands out port bytes and timer reloads on every timer expiry.
// ----------------------------------------------------------------------------
module servo_pulse_sequencer #(
  parameter int unsigned SERVO_COUNT = sps_pkg::ServoCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [sps_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sps_pkg::CmdW-1:0]      cmd_i,
  input  logic [sps_pkg::IdxW-1:0]      servo_number_i,
  input  logic                          turn_on_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sps_pkg::PortW-1:0]     port_bits_o,
  output logic [sps_pkg::ReloadW-1:0]   timer_reload_o
);

  sps_pkg::sps_item_t   in_item;
  sps_pkg::sps_item_t   stage_item;
  logic                 stage_valid;
  logic                 advance;
  logic                 fire;
  logic                 res_valid;
  sps_pkg::sps_result_t res;
  sps_pkg::sps_result_t out_res;
  sps_pkg::sps_status_t status;

  assign in_item.cmd          = cmd_i;
  assign in_item.servo_number = servo_number_i;
  assign in_item.turn_on      = turn_on_i;

  // Stage 1: capture the incoming transaction
  sps_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // Stage 2: update sequencer state; only one transaction touches the
  // state per cycle, so events, ticks and expiries stay in arrival order
  assign fire = stage_valid && advance;

  sps_engine #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  // Result register: decouples the sink from the state update
  sps_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign port_bits_o    = out_res.port_bits;
  assign timer_reload_o = out_res.timer_reload;

  // At most one servo is armed at a time
  a_one_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(status.active_mask))
    else $error("more than one servo armed");

  // A servo is armed exactly while frames remain
  a_armed_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((status.active_mask != '0) == (status.frames_left != '0)))
    else $error("armed mask and frame count disagree");

  // Input backpressure only comes from a stalled result register
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // A transaction left waiting in stage 1 is taken once the sink drains
  a_stage_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && out_ready_i) |-> fire)
    else $error("stage 1 did not advance with the sink ready");

endmodule
